### rtl/rgbser_pkg.sv
// Shared types, constants and helpers for the RGB LED one-wire serializer.
`default_nettype none

package rgbser_pkg;

    // Field widths
    localparam int unsigned COLOR_W = 24;
    localparam int unsigned LEDS_W  = 10;
    localparam int unsigned TICK_W  = 16;
    localparam int unsigned BIT_W   = 5;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 16;

    // Bits sent per LED
    localparam logic [BIT_W-1:0] BITS_PER_LED = 5'd24;

    // Default LED count limit
    localparam int MAX_LEDS_DEF = 1023;

    // Register reset values
    localparam logic [7:0]  ONE_HIGH_RST  = 8'd14;
    localparam logic [7:0]  ONE_LOW_RST   = 8'd12;
    localparam logic [7:0]  ZERO_HIGH_RST = 8'd7;
    localparam logic [7:0]  ZERO_LOW_RST  = 8'd16;
    localparam logic [15:0] LATCH_RST     = 16'd2000;

    // Register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ONE_HIGH  = 3'd0,
        REG_ONE_LOW   = 3'd1,
        REG_ZERO_HIGH = 3'd2,
        REG_ZERO_LOW  = 3'd3,
        REG_LATCH     = 3'd4
    } t_reg_idx;

    // Timing registers seen by the core
    typedef struct packed {
        logic [7:0]  one_high;
        logic [7:0]  one_low;
        logic [7:0]  zero_high;
        logic [7:0]  zero_low;
        logic [15:0] latch;
    } t_cfg;

    // One result item
    typedef struct packed {
        logic line_level;
        logic busy_res;
        logic frame_done;
        logic start_rejected;
    } t_result;

    // 0xRRGGBB -> transmit order 0xGGRRBB
    function automatic logic [COLOR_W-1:0] grb_order(input logic [COLOR_W-1:0] rgb);
        return {rgb[15:8], rgb[23:16], rgb[7:0]};
    endfunction

endpackage

`default_nettype wire

### rtl/rgbser_core.sv
// Serializer state machine: one tick item in, one line/status result out.
`default_nettype none

module rgbser_core #(
    parameter int MAX_LEDS = rgbser_pkg::MAX_LEDS_DEF
) (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  wire                               i_accept,
    input  wire                               i_command,
    input  wire  [rgbser_pkg::COLOR_W-1:0]    i_color,
    input  wire  [rgbser_pkg::LEDS_W-1:0]     i_led_count,
    input  rgbser_pkg::t_cfg                  i_cfg,
    output rgbser_pkg::t_result               o_result
);
    import rgbser_pkg::*;

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_SEND  = 2'd1,
        PH_LATCH = 2'd2
    } t_phase;

    localparam int CMP_W = 17;

    t_phase              r_phase,  n_phase;
    logic [COLOR_W-1:0]  r_held,   n_held;
    logic [COLOR_W-1:0]  r_shift,  n_shift;
    logic [BIT_W-1:0]    r_bit,    n_bit;
    logic [LEDS_W-1:0]   r_leds,   n_leds;
    logic [TICK_W-1:0]   r_tick,   n_tick;

    logic [7:0]          hi, lo;
    logic [8:0]          bit_total;
    logic [TICK_W-1:0]   tick_inc;
    logic [TICK_W-1:0]   latch_total;
    logic [BIT_W-1:0]    bit_next;
    logic [LEDS_W-1:0]   leds_dec;
    logic [LEDS_W-1:0]   count_sat;

    // A timing value of zero counts as one tick
    function automatic logic [7:0] nz8(input logic [7:0] v);
        return (v == 8'd0) ? 8'd1 : v;
    endfunction

    // Per-tick datapath
    always_comb begin
        n_phase  = r_phase;
        n_held   = r_held;
        n_shift  = r_shift;
        n_bit    = r_bit;
        n_leds   = r_leds;
        n_tick   = r_tick;
        o_result = '0;

        hi          = r_shift[COLOR_W-1] ? nz8(i_cfg.one_high) : nz8(i_cfg.zero_high);
        lo          = r_shift[COLOR_W-1] ? nz8(i_cfg.one_low)  : nz8(i_cfg.zero_low);
        bit_total   = {1'b0, hi} + {1'b0, lo};
        tick_inc    = r_tick + 16'd1;
        latch_total = (i_cfg.latch == 16'd0) ? 16'd1 : i_cfg.latch;
        bit_next    = r_bit + 5'd1;
        leds_dec    = (r_leds != '0) ? r_leds - 10'd1 : '0;
        count_sat   = ({7'b0, i_led_count} > CMP_W'(MAX_LEDS)) ?
                      LEDS_W'(MAX_LEDS) : i_led_count;

        if (i_accept) begin
            unique case (r_phase)
                PH_SEND: begin
                    o_result.busy_res       = 1'b1;
                    o_result.line_level     = (r_tick < {8'b0, hi});
                    o_result.start_rejected = i_command;
                    n_tick = tick_inc;
                    if (tick_inc >= {7'b0, bit_total}) begin
                        n_tick  = '0;
                        n_shift = {r_shift[COLOR_W-2:0], 1'b0};
                        n_bit   = bit_next;
                        if (bit_next >= BITS_PER_LED) begin
                            n_bit  = '0;
                            n_leds = leds_dec;
                            if (leds_dec == '0) begin
                                n_phase = PH_LATCH;
                            end else begin
                                n_shift = grb_order(r_held);
                            end
                        end
                    end
                end
                PH_LATCH: begin
                    o_result.busy_res       = 1'b1;
                    o_result.start_rejected = i_command;
                    n_tick = tick_inc;
                    if (tick_inc >= latch_total) begin
                        n_tick              = '0;
                        o_result.frame_done = 1'b1;
                        n_phase             = PH_IDLE;
                    end
                end
                default: begin
                    // idle, and the unused code
                    n_phase = PH_IDLE;
                    if (i_command) begin
                        o_result.busy_res = 1'b1;
                        n_held  = i_color;
                        n_shift = grb_order(i_color);
                        n_bit   = '0;
                        n_tick  = '0;
                        n_leds  = count_sat;
                        n_phase = (count_sat == '0) ? PH_LATCH : PH_SEND;
                    end
                end
            endcase
        end
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_held  <= '0;
            r_shift <= '0;
            r_bit   <= '0;
            r_leds  <= '0;
            r_tick  <= '0;
        end else begin
            r_phase <= n_phase;
            r_held  <= n_held;
            r_shift <= n_shift;
            r_bit   <= n_bit;
            r_leds  <= n_leds;
            r_tick  <= n_tick;
        end
    end

endmodule

`default_nettype wire

### rtl/rgb_led_one_wire_serializer_top.sv
// Top level: timing registers, serializer core and two-entry result buffer.
// Each tick result is registered into the result buffer when its item is accepted.
// Throughput: one tick item per cycle; the two-entry result buffer keeps
// input acceptance going while one result waits on output stall.
// Input stall rises only when both result entries are full.
// Reset (synchronous, active low) idles the serializer, empties the buffer and
// loads the timing registers with their defaults.
`default_nettype none

module rgb_led_one_wire_serializer_top #(
    parameter int MAX_LEDS = rgbser_pkg::MAX_LEDS_DEF
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    // tick items in
    input  wire                                 i_valid,
    output logic                                o_stall,
    input  wire                                 i_command,
    input  wire  [rgbser_pkg::COLOR_W-1:0]      i_color,
    input  wire  [rgbser_pkg::LEDS_W-1:0]       i_led_count,
    // results out
    output logic                                o_valid,
    input  wire                                 i_stall,
    output logic                                o_line_level,
    output logic                                o_busy_res,
    output logic                                o_frame_done,
    output logic                                o_start_rejected,
    // register writes
    input  wire                                 i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire  [rgbser_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire  [rgbser_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import rgbser_pkg::*;

    t_cfg       r_cfg;
    t_result    core_res;
    t_result    r_buf [2];
    logic       r_wr_ptr, r_rd_ptr;
    logic [1:0] r_count;
    logic       in_accept, out_accept;

    assign o_cfg_ready = 1'b1;
    assign o_stall     = (r_count == 2'd2);
    assign in_accept   = i_valid && !o_stall;
    assign out_accept  = o_valid && !i_stall;

    // Timing registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.one_high  <= ONE_HIGH_RST;
            r_cfg.one_low   <= ONE_LOW_RST;
            r_cfg.zero_high <= ZERO_HIGH_RST;
            r_cfg.zero_low  <= ZERO_LOW_RST;
            r_cfg.latch     <= LATCH_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                REG_ONE_HIGH:  r_cfg.one_high  <= i_cfg_data[7:0];
                REG_ONE_LOW:   r_cfg.one_low   <= i_cfg_data[7:0];
                REG_ZERO_HIGH: r_cfg.zero_high <= i_cfg_data[7:0];
                REG_ZERO_LOW:  r_cfg.zero_low  <= i_cfg_data[7:0];
                REG_LATCH:     r_cfg.latch     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    rgbser_core #(
        .MAX_LEDS (MAX_LEDS)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (in_accept),
        .i_command   (i_command),
        .i_color     (i_color),
        .i_led_count (i_led_count),
        .i_cfg       (r_cfg),
        .o_result    (core_res)
    );

    // Result buffer data
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_buf[r_wr_ptr] <= core_res;
        end
    end

    // Result buffer pointers and fill
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (in_accept)  r_wr_ptr <= ~r_wr_ptr;
            if (out_accept) r_rd_ptr <= ~r_rd_ptr;
            case ({in_accept, out_accept})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

    assign o_valid          = (r_count != 2'd0);
    assign o_line_level     = r_buf[r_rd_ptr].line_level;
    assign o_busy_res       = r_buf[r_rd_ptr].busy_res;
    assign o_frame_done     = r_buf[r_rd_ptr].frame_done;
    assign o_start_rejected = r_buf[r_rd_ptr].start_rejected;

endmodule

`default_nettype wire

### rtl/rgbser_checker.sv
// Port-level checks for the serializer top level, with its bind.
`default_nettype none

module rgbser_checker (
    input wire i_clk,
    input wire i_rst_n,
    input wire o_valid,
    input wire i_stall,
    input wire o_line_level,
    input wire o_busy_res,
    input wire o_frame_done,
    input wire o_start_rejected
);

    // Line is only driven high inside a frame
    a_line_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_line_level |-> o_busy_res)
        else $error("line high while not busy");

    // Frame done comes on a busy tick with the line low
    a_done_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_frame_done |-> o_busy_res && !o_line_level)
        else $error("frame done outside a busy tick");

    // A rejected start only happens while busy
    a_reject_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_start_rejected |-> o_busy_res)
        else $error("start rejected while idle");

    // Stalled result holds its line level and busy flag
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_line_level) && $stable(o_busy_res))
        else $error("stalled result changed");

endmodule

bind rgb_led_one_wire_serializer_top rgbser_checker u_rgbser_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .o_valid          (o_valid),
    .i_stall          (i_stall),
    .o_line_level     (o_line_level),
    .o_busy_res       (o_busy_res),
    .o_frame_done     (o_frame_done),
    .o_start_rejected (o_start_rejected)
);

`default_nettype wire

### tb/rgbser_line_checker.sv
// Line checker: predicts each tick result of the serializer and compares it with the block.
module rgbser_line_checker #(
    parameter int MAX_LEDS = rgbser_pkg::MAX_LEDS_DEF
) (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    // tick items into the block
    input  wire                               i_in_valid,
    input  wire                               i_in_stall,
    input  wire                               i_command,
    input  wire [rgbser_pkg::COLOR_W-1:0]     i_color,
    input  wire [rgbser_pkg::LEDS_W-1:0]      i_led_count,
    // results out of the block
    input  wire                               i_out_valid,
    input  wire                               i_out_stall,
    input  wire                               i_line_level,
    input  wire                               i_busy_res,
    input  wire                               i_frame_done,
    input  wire                               i_start_rejected,
    // register writes
    input  wire                               i_cfg_valid,
    input  wire                               i_cfg_ready,
    input  wire [rgbser_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire [rgbser_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    // status for the stimulus side
    output int                                o_mismatches,
    output int                                o_pending,
    output logic                              o_frame_idle
);
    timeunit 1ns;
    timeprecision 1ps;
    import rgbser_pkg::*;

    localparam int REPORT_LIMIT = 10;

    typedef enum logic [1:0] {
        LINE_IDLE  = 2'd0,
        LINE_SEND  = 2'd1,
        LINE_LATCH = 2'd2
    } t_line_phase;

    // Shadow copy of the serializer state and timing registers
    t_cfg                timing;
    t_line_phase         line_phase;
    logic [COLOR_W-1:0]  held_grb;
    logic [COLOR_W-1:0]  shift_word;
    logic [BIT_W-1:0]    bit_index;
    logic [LEDS_W-1:0]   leds_left;
    logic [TICK_W-1:0]   tick_count;

    t_result expected_ticks[$];
    int      result_count;

    assign o_frame_idle = (line_phase != LINE_SEND) && (line_phase != LINE_LATCH);

    // One tick of the serializer: advances the shadow state, returns the expected levels
    function automatic t_result line_tick(input logic cmd, input logic [COLOR_W-1:0] color,
                                          input logic [LEDS_W-1:0] count);
        t_result     r;
        int unsigned hi;
        int unsigned lo;
        int unsigned gap;
        int unsigned n;
        r = '0;
        case (line_phase)
            LINE_SEND: begin
                hi = shift_word[COLOR_W-1] ? timing.one_high : timing.zero_high;
                lo = shift_word[COLOR_W-1] ? timing.one_low : timing.zero_low;
                // a zero timing register still lasts one tick
                if (hi == 0) hi = 1;
                if (lo == 0) lo = 1;
                r.busy_res   = 1'b1;
                r.line_level = (tick_count < hi);
                tick_count   = tick_count + 1'b1;
                if (tick_count >= hi + lo) begin
                    tick_count = '0;
                    shift_word = {shift_word[COLOR_W-2:0], 1'b0};
                    bit_index  = bit_index + 1'b1;
                    if (bit_index >= BITS_PER_LED) begin
                        bit_index = '0;
                        if (leds_left != 0) leds_left = leds_left - 1'b1;
                        if (leds_left == 0) line_phase = LINE_LATCH;
                        else shift_word = held_grb;
                    end
                end
                r.start_rejected = cmd;
            end
            LINE_LATCH: begin
                gap        = (timing.latch == 0) ? 1 : timing.latch;
                r.busy_res = 1'b1;
                tick_count = tick_count + 1'b1;
                if (tick_count >= gap) begin
                    tick_count   = '0;
                    r.frame_done = 1'b1;
                    line_phase   = LINE_IDLE;
                end
                r.start_rejected = cmd;
            end
            default: begin
                // unused phase code behaves as idle
                line_phase = LINE_IDLE;
                if (cmd) begin
                    n          = (count > MAX_LEDS) ? MAX_LEDS : count;
                    r.busy_res = 1'b1;
                    // wire order is green, red, blue
                    held_grb   = {color[15:8], color[23:16], color[7:0]};
                    shift_word = {color[15:8], color[23:16], color[7:0]};
                    bit_index  = '0;
                    tick_count = '0;
                    leds_left  = n[LEDS_W-1:0];
                    line_phase = (n == 0) ? LINE_LATCH : LINE_SEND;
                end
            end
        endcase
        return r;
    endfunction

    // Watch the three channels: register writes, results, then new tick items
    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (!i_rst_n) begin
            timing.one_high  = ONE_HIGH_RST;
            timing.one_low   = ONE_LOW_RST;
            timing.zero_high = ZERO_HIGH_RST;
            timing.zero_low  = ZERO_LOW_RST;
            timing.latch     = LATCH_RST;
            line_phase       = LINE_IDLE;
            held_grb         = '0;
            shift_word       = '0;
            bit_index        = '0;
            leds_left        = '0;
            tick_count       = '0;
            expected_ticks.delete();
            result_count     = 0;
            o_mismatches     = 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    REG_ONE_HIGH:  timing.one_high  = i_cfg_data[7:0];
                    REG_ONE_LOW:   timing.one_low   = i_cfg_data[7:0];
                    REG_ZERO_HIGH: timing.zero_high = i_cfg_data[7:0];
                    REG_ZERO_LOW:  timing.zero_low  = i_cfg_data[7:0];
                    REG_LATCH:     timing.latch     = i_cfg_data[15:0];
                    default: ;
                endcase
            end
            if (i_out_valid && !i_out_stall) begin
                got = {i_line_level, i_busy_res, i_frame_done, i_start_rejected};
                if (expected_ticks.size() == 0) begin
                    o_mismatches++;
                    if (o_mismatches <= REPORT_LIMIT)
                        $display("result %0d arrived with no tick item pending: %b",
                                 result_count, got);
                end else begin
                    want = expected_ticks.pop_front();
                    if (got.line_level !== want.line_level || got.busy_res !== want.busy_res ||
                        got.frame_done !== want.frame_done ||
                        got.start_rejected !== want.start_rejected) begin
                        o_mismatches++;
                        if (o_mismatches <= REPORT_LIMIT)
                            $display({"result %0d mismatch (exp/got): line %b/%b busy %b/%b",
                                      " done %b/%b rejected %b/%b"}, result_count,
                                     want.line_level, got.line_level,
                                     want.busy_res, got.busy_res,
                                     want.frame_done, got.frame_done,
                                     want.start_rejected, got.start_rejected);
                    end
                end
                result_count++;
            end
            if (i_in_valid && !i_in_stall)
                expected_ticks.push_back(line_tick(i_command, i_color, i_led_count));
        end
        o_pending = expected_ticks.size();
    end

endmodule

### tb/tb_top.sv
// Testbench top: clock, reset, tick and register stimulus, watchdog and verdict.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import rgbser_pkg::*;

    localparam int IDLE_PCT     = 28;
    localparam int STALL_LIMIT  = 2000;
    localparam int RANDOM_TICKS = 50;
    localparam int RANDOM_SETS  = 4;

    logic                   i_clk       = 1'b0;
    logic                   i_rst_n     = 1'b0;
    logic                   i_valid     = 1'b0;
    logic                   o_stall;
    logic                   i_command   = 1'b0;
    logic [COLOR_W-1:0]     i_color     = '0;
    logic [LEDS_W-1:0]      i_led_count = '0;
    logic                   o_valid;
    logic                   i_stall     = 1'b0;
    logic                   o_line_level;
    logic                   o_busy_res;
    logic                   o_frame_done;
    logic                   o_start_rejected;
    logic                   i_cfg_valid = 1'b0;
    logic                   o_cfg_ready;
    logic [CFG_IDX_W-1:0]   i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_data  = '0;

    int   mismatches;
    int   pending;
    logic frame_idle;
    bit   steady      = 1'b0;
    int   ticks_sent  = 0;
    int   idle_cycles = 0;

    rgb_led_one_wire_serializer_top dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_command        (i_command),
        .i_color          (i_color),
        .i_led_count      (i_led_count),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_line_level     (o_line_level),
        .o_busy_res       (o_busy_res),
        .o_frame_done     (o_frame_done),
        .o_start_rejected (o_start_rejected),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data)
    );

    rgbser_line_checker u_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_valid),
        .i_in_stall       (o_stall),
        .i_command        (i_command),
        .i_color          (i_color),
        .i_led_count      (i_led_count),
        .i_out_valid      (o_valid),
        .i_out_stall      (i_stall),
        .i_line_level     (o_line_level),
        .i_busy_res       (o_busy_res),
        .i_frame_done     (o_frame_done),
        .i_start_rejected (o_start_rejected),
        .i_cfg_valid      (i_cfg_valid),
        .i_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .o_mismatches     (mismatches),
        .o_pending        (pending),
        .o_frame_idle     (frame_idle)
    );

    always #1 i_clk = ~i_clk;

    // Result side stalls at random, except in steady stretches
    always @(negedge i_clk) begin
        i_stall <= !steady && ($urandom_range(99) < IDLE_PCT);
    end

    // Watchdog on cycles where no channel moves anything
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall) ||
            (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("FAIL rgb_led_one_wire_serializer_top");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    function automatic logic [COLOR_W-1:0] rand_color();
        logic [31:0] r;
        r = $urandom;
        return r[COLOR_W-1:0];
    endfunction

    function automatic logic [LEDS_W-1:0] rand_count();
        logic [31:0] r;
        r = $urandom;
        return r[LEDS_W-1:0];
    endfunction

    // Called at a falling edge; returns at the falling edge after the item is taken
    task automatic send_tick(input logic cmd, input logic [COLOR_W-1:0] color,
                             input logic [LEDS_W-1:0] count);
        while (!steady && $urandom_range(99) < IDLE_PCT) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid     <= 1'b1;
        i_command   <= cmd;
        i_color     <= color;
        i_led_count <= count;
        do @(posedge i_clk); while (o_stall);
        ticks_sent++;
        @(negedge i_clk);
    endtask

    // Plain ticks, with stray starts mixed in, until the frame is over
    task automatic run_to_idle(input int start_pct);
        while (!frame_idle)
            send_tick($urandom_range(99) < start_pct, rand_color(), rand_count());
    endtask

    // Sender goes quiet until every result is back
    task automatic drain();
        i_valid <= 1'b0;
        do @(negedge i_clk); while (pending != 0);
    endtask

    task automatic frame(input logic [COLOR_W-1:0] color, input logic [LEDS_W-1:0] count,
                         input int start_pct, input bit hold_midway);
        send_tick(1'b1, color, count);
        if (hold_midway) begin
            repeat (150) if (!frame_idle) send_tick(1'b0, rand_color(), rand_count());
            drain();
        end
        run_to_idle(start_pct);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
    endtask

    // All five timing registers; junk in the unused upper byte of the 8-bit ones
    task automatic load_timing(input logic [7:0] one_hi, input logic [7:0] one_lo,
                               input logic [7:0] zero_hi, input logic [7:0] zero_lo,
                               input logic [15:0] gap);
        logic [31:0] r;
        r = $urandom;
        drain();
        repeat (2) @(negedge i_clk);
        cfg_write(REG_ONE_HIGH, {r[7:0], one_hi});
        cfg_write(REG_ONE_LOW, {r[15:8], one_lo});
        cfg_write(REG_ZERO_HIGH, {r[23:16], zero_hi});
        cfg_write(REG_ZERO_LOW, {r[31:24], zero_lo});
        cfg_write(REG_LATCH, gap);
        i_cfg_valid <= 1'b0;
    endtask

    initial begin
        logic [31:0]          r;
        logic [CFG_IDX_W-1:0] idx;
        logic [LEDS_W-1:0]    leds;
        int                   pick;
        int                   set_start;

        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Reset timing for the first bits of a frame; the sender then waits for
        // every result and shorter timing takes over mid-frame
        send_tick(1'b1, 24'hC03A5F, 10'd1);
        repeat (150) send_tick(1'b0, rand_color(), rand_count());
        load_timing(8'd2, 8'd1, 8'd1, 8'd2, 16'd5);
        run_to_idle(3);

        // Register writes outside the list must change nothing
        drain();
        repeat (2) @(negedge i_clk);
        for (int k = REG_LATCH + 1; k < (1 << CFG_IDX_W); k++) begin
            r   = $urandom;
            idx = k[CFG_IDX_W-1:0];
            cfg_write(idx, r[CFG_DATA_W-1:0]);
        end
        // Zero in every register: each acts as a single tick
        load_timing(8'd0, 8'd0, 8'd0, 8'd0, 16'd0);
        frame(24'hFFFFFF, 10'd1, 100, 1'b0);
        frame(24'h000000, 10'd1, 0, 1'b0);
        frame(24'hFF0000, 10'd2, 10, 1'b1);
        frame(24'h00FF00, 10'd1, 10, 1'b0);
        frame(24'h0000FF, 10'd1, 10, 1'b0);
        frame(24'h123456, 10'd0, 0, 1'b0);
        frame(24'h654321, 10'd0, 100, 1'b0);

        // Ones and zeros told apart by their high and low times
        load_timing(8'd1, 8'd2, 8'd2, 8'd1, 16'd1);
        frame(24'h800001, 10'd1, 0, 1'b0);
        frame(24'h5A5A5A, 10'd1, 20, 1'b0);

        // Longest high time: a single one bit among zeros
        load_timing(8'd255, 8'd1, 8'd1, 8'd1, 16'd2);
        frame(24'h000001, 10'd1, 1, 1'b0);

        // Random short timings, frames with random content and stray starts
        for (int s = 0; s < RANDOM_SETS; s++) begin
            r = $urandom;
            load_timing({6'd0, r[1:0]}, {6'd0, r[3:2]}, {6'd0, r[5:4]}, {6'd0, r[7:6]},
                        {13'd0, r[10:8]});
            steady    <= (s == 1) || (s == 2);
            set_start = ticks_sent;
            while (ticks_sent - set_start < RANDOM_TICKS) begin
                repeat ($urandom_range(3)) send_tick(1'b0, rand_color(), rand_count());
                pick = $urandom_range(99);
                if (pick < 25) begin
                    leds = '0;
                end else if (pick < 90) begin
                    r    = $urandom_range(2, 1);
                    leds = r[LEDS_W-1:0];
                end else begin
                    r    = $urandom_range(4, 3);
                    leds = r[LEDS_W-1:0];
                end
                frame(rand_color(), leds, 15, 1'b0);
            end
        end

        drain();
        repeat (4) @(negedge i_clk);
        if (mismatches == 0 && pending == 0)
            $display("PASS rgb_led_one_wire_serializer_top");
        else
            $display("FAIL rgb_led_one_wire_serializer_top");
        $finish;
    end

endmodule
